[hdl/box_blur_window_mean_assert.svh]
// ----------------------------------------------------------------------------
// Box blur window mean - assertion macros
// Shared property forms for the block's checkers.
// ----------------------------------------------------------------------------
`ifndef BOX_BLUR_WINDOW_MEAN_ASSERT_SVH
`define BOX_BLUR_WINDOW_MEAN_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define BBWM_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked from the cycle after the antecedent
`define BBWM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/bbwm_pkg.sv]
// ----------------------------------------------------------------------------
// Box blur window mean - package
// Sizes, register indexes and operation codes shared by the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bbwm_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;

  localparam int PIX_W      = 8;
  localparam int CFG_DIM_W  = 9;
  localparam int RAD_W      = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  localparam int COL_W   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int ROW_W   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int MAX_DIM = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int DIM_W   = $clog2(MAX_DIM + 1);
  localparam int GEO_W   = ((DIM_W > RAD_W) ? DIM_W : RAD_W) + 1;

  localparam int ADDR_W    = ROW_W + COL_W;
  localparam int RAM_DEPTH = 1 << ADDR_W;
  localparam int SUM_W     = PIX_W + ADDR_W;
  localparam int RS_W      = PIX_W + COL_W;
  localparam int CNT_W     = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);

  localparam logic [CFG_DIM_W-1:0] FRAME_WIDTH_RST  = CFG_DIM_W'(256);
  localparam logic [CFG_DIM_W-1:0] FRAME_HEIGHT_RST = CFG_DIM_W'(256);
  localparam logic [RAD_W-1:0]     RADIUS_RST       = RAD_W'(1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_RADIUS       = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    OP_LOAD    = 1'b0,
    OP_PRODUCE = 1'b1
  } op_t;

endpackage

[hdl/bbwm_ram.sv]
// ----------------------------------------------------------------------------
// Box blur window mean - generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bbwm_ram #(
  parameter  int DATA_W = 8,
  parameter  int DEPTH  = 256,
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic [AW-1:0]     rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

[hdl/bbwm_div.sv]
// ----------------------------------------------------------------------------
// Box blur window mean - divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bbwm_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [bbwm_pkg::SUM_W-1:0] dividend,
  input  logic [bbwm_pkg::CNT_W-1:0] divisor,
  output logic                       done,
  output logic [bbwm_pkg::SUM_W-1:0] quotient
);

  import bbwm_pkg::*;

  localparam int ITER_W = $clog2(SUM_W + 1);

  logic              busy_r;
  logic              done_r;
  logic [ITER_W-1:0] iter_r;
  logic [SUM_W-1:0]  quo_r;
  logic [CNT_W-1:0]  rem_r;
  logic [CNT_W-1:0]  divisor_r;
  logic [CNT_W:0]    rem_sh;
  logic [CNT_W:0]    rem_diff;
  logic              fits;

  assign rem_sh   = {rem_r, quo_r[SUM_W-1]};
  assign fits     = (rem_sh >= {1'b0, divisor_r});
  assign rem_diff = rem_sh - {1'b0, divisor_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
    end else if (busy_r && (iter_r == ITER_W'(1))) begin
      busy_r <= 1'b0;
      done_r <= 1'b1;
    end

    if (start) begin
      quo_r     <= dividend;
      rem_r     <= '0;
      divisor_r <= divisor;
      iter_r    <= ITER_W'(SUM_W);
    end else if (busy_r) begin
      quo_r  <= {quo_r[SUM_W-2:0], fits};
      rem_r  <= fits ? rem_diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
      iter_r <= iter_r - ITER_W'(1);
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

[hdl/box_blur_window_mean.sv]
// ----------------------------------------------------------------------------
// Box blur window mean - top level
// Loads a grey frame into a summed-area table, then gives the mean of the
// clipped window around each pixel in raster order on request.
// ----------------------------------------------------------------------------
// Channel  Direction  Beat
// in_      slave      tuser[0] operation, tdata[7:0] pixel
// out_     master     tdata[7:0] blurred, tlast end of frame
// cfg_     write      index 0 width, 1 height, 2 radius
//
// Load steps: accept, table read, table write with the row sum.
// Produce steps: accept, window bounds, 4 table reads on one port, divider
// start, 24 divider steps and taking the quotient once the output is free.
// A produce beat before a full frame is accepted and gives nothing.
// Sync reset, no clearing pass. A stalled result stalls the next produce beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module box_blur_window_mean (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [bbwm_pkg::PIX_W-1:0]      in_tdata,   // [7:0] pixel
  input  logic [0:0]                      in_tuser,   // [0] operation
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [bbwm_pkg::PIX_W-1:0]      out_tdata,  // [7:0] blurred
  output logic                            out_tlast,
  input  logic                            cfg_we,
  input  logic [bbwm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bbwm_pkg::CFG_DATA_W-1:0] cfg_data
);

  import bbwm_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LD_RD,
    S_LD_WR,
    S_GEO,
    S_RD_A,
    S_RD_B,
    S_RD_C,
    S_RD_D,
    S_SUM,
    S_DIV
  } state_t;

  state_t               state_r, state_nxt;
  logic [CFG_DIM_W-1:0] width_r, width_nxt;
  logic [CFG_DIM_W-1:0] height_r, height_nxt;
  logic [RAD_W-1:0]     radius_r, radius_nxt;
  logic [ROW_W-1:0]     load_row_r, load_row_nxt;
  logic [COL_W-1:0]     load_col_r, load_col_nxt;
  logic [ROW_W-1:0]     out_row_r, out_row_nxt;
  logic [COL_W-1:0]     out_col_r, out_col_nxt;
  logic                 frame_ready_r, frame_ready_nxt;
  logic                 out_tvalid_r, out_tvalid_nxt;
  logic [PIX_W-1:0]     out_tdata_r, out_tdata_nxt;
  logic                 out_tlast_r, out_tlast_nxt;
  logic [RS_W-1:0]      rowsum_r, rowsum_nxt;
  logic [ROW_W-1:0]     top_r, top_nxt;
  logic [COL_W-1:0]     left_r, left_nxt;
  logic [DIM_W-1:0]     bot_r, bot_nxt;
  logic [DIM_W-1:0]     right_r, right_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [SUM_W-1:0]     acc_r, acc_nxt;

  logic [GEO_W-1:0] w_eff, h_eff, rad_eff;
  logic [GEO_W-1:0] g_row, g_col, g_row_hi, g_col_hi;
  logic [GEO_W-1:0] ld_col_inc, ld_row_inc, o_col_inc, o_row_inc;
  logic [DIM_W-1:0] span_h, span_w;
  logic [ROW_W-1:0] top_m1, bot_m1;
  logic [COL_W-1:0] left_m1, right_m1;
  logic [COL_W-1:0] ld_col_now;
  logic             in_acc, out_free, out_last;
  logic             top_nz, left_nz;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_wr_addr, ram_rd_addr;
  logic [SUM_W-1:0]  ram_wr_data, ram_rd_data;

  logic             div_start, div_done;
  logic [SUM_W-1:0] div_dividend, div_quo;

  assign w_eff = (width_r == '0) ? GEO_W'(1) :
                 (GEO_W'(width_r) > GEO_W'(MAX_WIDTH)) ? GEO_W'(MAX_WIDTH) :
                 GEO_W'(width_r);
  assign h_eff = (height_r == '0) ? GEO_W'(1) :
                 (GEO_W'(height_r) > GEO_W'(MAX_HEIGHT)) ? GEO_W'(MAX_HEIGHT) :
                 GEO_W'(height_r);
  assign rad_eff = (radius_r == '0) ? GEO_W'(1) : GEO_W'(radius_r);

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_tvalid_r || out_tready;

  assign g_row    = GEO_W'(out_row_r);
  assign g_col    = GEO_W'(out_col_r);
  assign g_row_hi = (g_row + rad_eff < h_eff) ? g_row + rad_eff : h_eff;
  assign g_col_hi = (g_col + rad_eff < w_eff) ? g_col + rad_eff : w_eff;

  assign ld_col_inc = GEO_W'(load_col_r) + GEO_W'(1);
  assign ld_row_inc = GEO_W'(load_row_r) + GEO_W'(1);
  assign o_col_inc  = g_col + GEO_W'(1);
  assign o_row_inc  = g_row + GEO_W'(1);
  assign out_last   = (o_row_inc >= h_eff) && (o_col_inc >= w_eff);
  assign ld_col_now = frame_ready_r ? '0 : load_col_r;

  assign span_h   = bot_r - DIM_W'(top_r);
  assign span_w   = right_r - DIM_W'(left_r);
  assign top_m1   = top_r - ROW_W'(1);
  assign left_m1  = left_r - COL_W'(1);
  assign bot_m1   = ROW_W'(bot_r - DIM_W'(1));
  assign right_m1 = COL_W'(right_r - DIM_W'(1));
  assign top_nz   = (top_r != '0);
  assign left_nz  = (left_r != '0);

  // table entry = entry above + running sum of the current row
  assign ram_we      = (state_r == S_LD_WR);
  assign ram_wr_addr = {load_row_r, load_col_r};
  assign ram_wr_data = ((load_row_r == '0) ? '0 : ram_rd_data) + SUM_W'(rowsum_r);

  always_comb begin
    case (state_r)
      S_LD_RD: ram_rd_addr = {load_row_r - ROW_W'(1), load_col_r};
      S_RD_A:  ram_rd_addr = {bot_m1, right_m1};
      S_RD_B:  ram_rd_addr = {top_m1, right_m1};
      S_RD_C:  ram_rd_addr = {bot_m1, left_m1};
      S_RD_D:  ram_rd_addr = {top_m1, left_m1};
      default: ram_rd_addr = '0;
    endcase
  end

  assign div_start    = (state_r == S_SUM);
  assign div_dividend = acc_r + ((top_nz && left_nz) ? ram_rd_data : '0);

  bbwm_ram #(
    .DATA_W (SUM_W),
    .DEPTH  (RAM_DEPTH)
  ) u_sat (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  bbwm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (count_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_comb begin
    state_nxt       = state_r;
    width_nxt       = width_r;
    height_nxt      = height_r;
    radius_nxt      = radius_r;
    load_row_nxt    = load_row_r;
    load_col_nxt    = load_col_r;
    out_row_nxt     = out_row_r;
    out_col_nxt     = out_col_r;
    frame_ready_nxt = frame_ready_r;
    out_tvalid_nxt  = out_tvalid_r;
    out_tdata_nxt   = out_tdata_r;
    out_tlast_nxt   = out_tlast_r;
    rowsum_nxt      = rowsum_r;
    top_nxt         = top_r;
    left_nxt        = left_r;
    bot_nxt         = bot_r;
    right_nxt       = right_r;
    count_nxt       = count_r;
    acc_nxt         = acc_r;

    if (out_tvalid_r && out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_tuser[0] == OP_LOAD) begin
            if (frame_ready_r) begin
              load_row_nxt    = '0;
              load_col_nxt    = '0;
              out_row_nxt     = '0;
              out_col_nxt     = '0;
              frame_ready_nxt = 1'b0;
            end
            rowsum_nxt = ((ld_col_now == '0) ? '0 : rowsum_r) + RS_W'(in_tdata);
            state_nxt  = S_LD_RD;
          end else if (frame_ready_r) begin
            state_nxt = S_GEO;
          end
        end
      end
      S_LD_RD: begin
        state_nxt = S_LD_WR;
      end
      S_LD_WR: begin
        if (ld_col_inc >= w_eff) begin
          load_col_nxt = '0;
          if (ld_row_inc >= h_eff) begin
            load_row_nxt    = '0;
            out_row_nxt     = '0;
            out_col_nxt     = '0;
            frame_ready_nxt = 1'b1;
          end else begin
            load_row_nxt = ROW_W'(ld_row_inc);
          end
        end else begin
          load_col_nxt = COL_W'(ld_col_inc);
        end
        state_nxt = S_IDLE;
      end
      S_GEO: begin
        top_nxt   = ROW_W'((g_row >= rad_eff) ? g_row - rad_eff : '0);
        left_nxt  = COL_W'((g_col >= rad_eff) ? g_col - rad_eff : '0);
        bot_nxt   = DIM_W'(g_row_hi);
        right_nxt = DIM_W'(g_col_hi);
        state_nxt = S_RD_A;
      end
      S_RD_A: begin
        count_nxt = CNT_W'(span_h) * CNT_W'(span_w);
        state_nxt = S_RD_B;
      end
      S_RD_B: begin
        acc_nxt   = ram_rd_data;
        state_nxt = S_RD_C;
      end
      S_RD_C: begin
        acc_nxt   = acc_r - (top_nz ? ram_rd_data : '0);
        state_nxt = S_RD_D;
      end
      S_RD_D: begin
        acc_nxt   = acc_r - (left_nz ? ram_rd_data : '0);
        state_nxt = S_SUM;
      end
      S_SUM: begin
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_done && out_free) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = div_quo[PIX_W-1:0];
          out_tlast_nxt  = out_last;
          if (o_col_inc >= w_eff) begin
            out_col_nxt = '0;
            out_row_nxt = (o_row_inc >= h_eff) ? '0 : ROW_W'(o_row_inc);
          end else begin
            out_col_nxt = COL_W'(o_col_inc);
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_WIDTH: begin
          width_nxt       = cfg_data[CFG_DIM_W-1:0];
          load_row_nxt    = '0;
          load_col_nxt    = '0;
          out_row_nxt     = '0;
          out_col_nxt     = '0;
          frame_ready_nxt = 1'b0;
        end
        REG_FRAME_HEIGHT: begin
          height_nxt      = cfg_data[CFG_DIM_W-1:0];
          load_row_nxt    = '0;
          load_col_nxt    = '0;
          out_row_nxt     = '0;
          out_col_nxt     = '0;
          frame_ready_nxt = 1'b0;
        end
        REG_RADIUS: begin
          radius_nxt = cfg_data[RAD_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      width_r       <= FRAME_WIDTH_RST;
      height_r      <= FRAME_HEIGHT_RST;
      radius_r      <= RADIUS_RST;
      load_row_r    <= '0;
      load_col_r    <= '0;
      out_row_r     <= '0;
      out_col_r     <= '0;
      frame_ready_r <= 1'b0;
      out_tvalid_r  <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      width_r       <= width_nxt;
      height_r      <= height_nxt;
      radius_r      <= radius_nxt;
      load_row_r    <= load_row_nxt;
      load_col_r    <= load_col_nxt;
      out_row_r     <= out_row_nxt;
      out_col_r     <= out_col_nxt;
      frame_ready_r <= frame_ready_nxt;
      out_tvalid_r  <= out_tvalid_nxt;
    end
    out_tdata_r <= out_tdata_nxt;
    out_tlast_r <= out_tlast_nxt;
    rowsum_r    <= rowsum_nxt;
    top_r       <= top_nxt;
    left_r      <= left_nxt;
    bot_r       <= bot_nxt;
    right_r     <= right_nxt;
    count_r     <= count_nxt;
    acc_r       <= acc_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;

endmodule

[hdl/bbwm_chk.sv]
// ----------------------------------------------------------------------------
// Box blur window mean - port checker
// Watches the top-level ports over time; bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "box_blur_window_mean_assert.svh"

module bbwm_chk (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic [bbwm_pkg::PIX_W-1:0]      in_tdata,
  input logic [0:0]                      in_tuser,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [bbwm_pkg::PIX_W-1:0]      out_tdata,
  input logic                            out_tlast,
  input logic                            cfg_we,
  input logic [bbwm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input logic [bbwm_pkg::CFG_DATA_W-1:0] cfg_data
);

  import bbwm_pkg::*;

  logic           in_acc;
  logic           load_acc;
  logic           out_stall;
  logic [PIX_W:0] out_beat;
  logic           in_known;
  logic           cfg_known;

  assign in_acc    = in_tvalid && in_tready;
  assign load_acc  = in_acc && (in_tuser[0] == OP_LOAD);
  assign out_stall = out_tvalid && !out_tready;
  assign out_beat  = {out_tlast, out_tdata};
  assign in_known  = !$isunknown(in_tuser) && !$isunknown(in_tdata);
  assign cfg_known = !$isunknown(cfg_index) && !$isunknown(cfg_data);

  `BBWM_ASSERT_NEXT(a_out_hold, out_stall, out_tvalid && $stable(out_beat), "stalled beat lost")

  `BBWM_ASSERT_NEXT(a_load_busy, load_acc, !in_tready ##1 !in_tready, "load finished too early")

  `BBWM_ASSERT_SAME(a_out_after_busy, $rose(out_tvalid), $past(!in_tready), "result without work")

  `BBWM_ASSERT_SAME(a_in_known, in_acc, in_known, "unknown input beat")

  `BBWM_ASSERT_SAME(a_cfg_idle, cfg_we, in_tready && !out_tvalid && cfg_known, "config write when busy")

endmodule

bind box_blur_window_mean bbwm_chk u_bbwm_chk (.*);

[tb/tb.sv]
// ----------------------------------------------------------------------------
// Box blur window mean - testbench
// Loads grey frames of many shapes and asks for blurred pixels in raster
// order. A scoreboard keeps its own copy of the frame store, positions and
// registers, works out the mean of each clipped window and checks every
// output beat against it. Both sides of the stream stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import bbwm_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(3);

  typedef struct packed {
    logic [PIX_W-1:0] blurred;
    logic             last;
  } blur_beat_t;

  class blur_tracker;
    bit [PIX_W-1:0]     store [MAX_WIDTH*MAX_HEIGHT];
    int unsigned        ld_row, ld_col, px_row, px_col;
    bit                 ready;
    bit [CFG_DIM_W-1:0] width_reg, height_reg;
    bit [RAD_W-1:0]     radius_reg;
    blur_beat_t         pending_pixels[$];
    int                 fails;

    function new();
      width_reg  = FRAME_WIDTH_RST;
      height_reg = FRAME_HEIGHT_RST;
      radius_reg = RADIUS_RST;
      fails      = 0;
      restart();
    endfunction

    function void restart();
      ld_row = 0;
      ld_col = 0;
      px_row = 0;
      px_col = 0;
      ready  = 1'b0;
    endfunction

    function int unsigned cols();
      if (width_reg == 0) return 1;
      if (width_reg > MAX_WIDTH) return MAX_WIDTH;
      return 32'(width_reg);
    endfunction

    function int unsigned rows();
      if (height_reg == 0) return 1;
      if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
      return 32'(height_reg);
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_FRAME_WIDTH: begin
          width_reg = val;
          restart();
        end
        REG_FRAME_HEIGHT: begin
          height_reg = val;
          restart();
        end
        REG_RADIUS: begin
          radius_reg = val[RAD_W-1:0];
        end
        default: ;
      endcase
    endfunction

    // mean over rows [i-r, i+r) and columns [j-r, j+r), clipped to the frame
    function logic [PIX_W-1:0] window_mean_of(int unsigned i, int unsigned j,
                                              int unsigned w, int unsigned h);
      int unsigned r, top, bot, lft, rgt, sum, cnt;
      r   = (radius_reg == 0) ? 1 : radius_reg;
      top = (i >= r) ? i - r : 0;
      bot = (i + r < h) ? i + r : h;
      lft = (j >= r) ? j - r : 0;
      rgt = (j + r < w) ? j + r : w;
      sum = 0;
      for (int unsigned k = top; k < bot; k++)
        for (int unsigned l = lft; l < rgt; l++)
          sum += store[k*MAX_WIDTH + l];
      cnt = (bot - top) * (rgt - lft);
      if (cnt == 0) return '0;
      return PIX_W'(sum / cnt);
    endfunction

    function void note_input(op_t op, logic [PIX_W-1:0] pix);
      int unsigned w, h;
      blur_beat_t  b;
      w = cols();
      h = rows();
      if (op == OP_LOAD) begin
        if (ready) restart();
        store[ld_row*MAX_WIDTH + ld_col] = pix;
        ld_col++;
        if (ld_col >= w) begin
          ld_col = 0;
          ld_row++;
          if (ld_row >= h) begin
            ld_row = 0;
            px_row = 0;
            px_col = 0;
            ready  = 1'b1;
          end
        end
      end else if (ready) begin
        b.blurred = window_mean_of(px_row, px_col, w, h);
        b.last    = (px_row + 1 >= h) && (px_col + 1 >= w);
        pending_pixels = {pending_pixels, b};
        px_col++;
        if (px_col >= w) begin
          px_col = 0;
          px_row++;
          if (px_row >= h) px_row = 0;
        end
      end
    endfunction

    function void check(logic [PIX_W-1:0] blurred, logic last);
      blur_beat_t b;
      if (pending_pixels.size() == 0) begin
        $error("unexpected output beat: blurred %0d last %0d", blurred, last);
        fails++;
        return;
      end
      b = pending_pixels.pop_front();
      if (blurred !== b.blurred) begin
        $error("blurred: expected %0d, got %0d", b.blurred, blurred);
        fails++;
      end
      if (last !== b.last) begin
        $error("last: expected %0d, got %0d", b.last, last);
        fails++;
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [PIX_W-1:0]     in_tdata = '0;    // [7:0] pixel
  logic [0:0]           in_tuser = '0;    // [0] operation
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [PIX_W-1:0]     out_tdata;        // [7:0] blurred
  logic                 out_tlast;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  blur_tracker blur = new();
  bit          calm = 1'b0;
  int          sent = 0;

  box_blur_window_mean i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) blur.check(out_tdata, out_tlast);
    out_tready <= calm || ($urandom_range(99) >= 8);
  end

  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic logic [PIX_W-1:0] rand_pixel();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return PIX_W'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] rand_radius();
    case ($urandom_range(9))
      0:       return '0;
      1:       return CFG_DATA_W'(255);
      default: return CFG_DATA_W'($urandom_range(1, 5));
    endcase
  endfunction

  task automatic send_beat(op_t op, logic [PIX_W-1:0] pix);
    while (!calm && $urandom_range(99) < 8) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= pix;
    do @(posedge clk); while (!in_tready);
    blur.note_input(op, pix);
    sent++;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (blur.pending_pixels.size() != 0);
  endtask

  // idle long enough for a request that gives no beat to finish as well
  task automatic settle();
    drain();
    repeat (40) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    blur.write_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic configure(logic [CFG_DATA_W-1:0] w, logic [CFG_DATA_W-1:0] h,
                           logic [CFG_DATA_W-1:0] r);
    settle();
    cfg_write(REG_FRAME_WIDTH, w);
    cfg_write(REG_FRAME_HEIGHT, h);
    cfg_write(REG_RADIUS, r);
  endtask

  task automatic load_frame(int n, bit noisy);
    for (int k = 0; k < n; k++) begin
      if (noisy && $urandom_range(99) < 8) send_beat(OP_PRODUCE, rand_pixel());
      send_beat(OP_LOAD, rand_pixel());
    end
  endtask

  task automatic produce(int n);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(99) < 3) drain();
      send_beat(OP_PRODUCE, rand_pixel());
    end
  endtask

  initial begin
    int n;
    int phase;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // request before any frame, then a partial frame dropped by a resize
    send_beat(OP_PRODUCE, 8'hFF);
    send_beat(OP_LOAD, 8'h5A);
    configure(3, 2, 0);
    send_beat(OP_LOAD, 8'h00);
    send_beat(OP_LOAD, 8'hFF);
    send_beat(OP_LOAD, 8'h80);
    send_beat(OP_LOAD, 8'h7F);
    send_beat(OP_PRODUCE, 8'h00);
    send_beat(OP_LOAD, 8'h01);
    send_beat(OP_LOAD, 8'hFE);
    produce(7);
    // load after a complete frame starts over
    send_beat(OP_LOAD, 8'hC3);
    send_beat(OP_PRODUCE, 8'h55);

    phase = 0;
    while (sent < 1350) begin
      calm = (phase >= 2 && phase < 5);
      if (phase == 3) begin
        configure(511, 0, 255);
        load_frame(256, 1'b0);
        produce(258);
      end else if (phase == 7) begin
        configure(0, 300, 0);
        load_frame(256, 1'b0);
        produce(12);
      end else begin
        configure(CFG_DATA_W'($urandom_range(0, 9)), CFG_DATA_W'($urandom_range(0, 7)),
                  rand_radius());
        if ($urandom_range(3) == 0) cfg_write(REG_UNUSED, CFG_DATA_W'($urandom_range(511)));
        n = blur.cols() * blur.rows();
        if ($urandom_range(9) == 0) begin
          load_frame($urandom_range(0, n - 1), 1'b1);
        end else begin
          load_frame(n, 1'b1);
          produce($urandom_range(1, 2*n + 1));
          if ($urandom_range(99) < 40) begin
            settle();
            cfg_write(REG_RADIUS, rand_radius());
            produce($urandom_range(1, n));
          end
          if ($urandom_range(99) < 30) begin
            load_frame(n, 1'b1);
            produce($urandom_range(1, 2*n + 1));
          end
        end
      end
      phase++;
    end

    calm = 1'b0;
    drain();
    repeat (64) @(posedge clk);
    if (blur.fails == 0 && blur.pending_pixels.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
